### design/gds_pkg.sv
// graph distance sum package: sizes, widths and controller state codes
// no dependencies; imported by the top level
`default_nettype none
package gds_pkg;
	localparam int MAX_NODES  = 64;
	localparam int MAX_DEGREE = 8;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int SLOT_W     = $clog2(MAX_DEGREE);
	localparam int ADJ_DEPTH  = MAX_NODES * MAX_DEGREE;
	localparam int ADJ_AW     = NODE_W + SLOT_W;
	localparam int ADJ_W      = NODE_W + 1;
	localparam int CNT_W      = NODE_W + 1;
	localparam int DIST_W     = 7;
	localparam int QUE_W      = NODE_W + DIST_W;
	localparam int SUM_W      = 18;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [2:0] REG_NODE_COUNT = 3'd0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SRC_INIT,
		ST_POP,
		ST_POP_WAIT,
		ST_NBR
	} gds_state_t;
endpackage
`default_nettype wire

### design/graph_distance_sum.sv
// graph distance sum top level: adjacency ram, breadth-first queue ram, controller
// depends on gds_pkg and gds_ram
// load word: accepted back to back while busy is low. compute word: per source, a
// queue read, then 8 slot reads from the adjacency ram port for each reached node.
// the sum is shown on distance_sum with done for one cycle; the receiver cannot stall.
// after reset all 512 adjacency ram entries are cleared with busy high.
`default_nettype none
module graph_distance_sum (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          mode,
	input  wire logic [gds_pkg::NODE_W-1:0]    node_index,
	input  wire logic [gds_pkg::SLOT_W-1:0]    slot_index,
	input  wire logic [gds_pkg::NODE_W-1:0]    neighbor_node,
	input  wire logic                          slot_present,
	output logic                               done,
	output logic      [gds_pkg::SUM_W-1:0]     distance_sum,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [2:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);
	import gds_pkg::*;

	gds_state_t state_q, state_d;

	logic [CNT_W-1:0]     node_count_q;
	logic [CNT_W-1:0]     n_eff;
	logic [ADJ_AW:0]      clr_q;
	logic [NODE_W-1:0]    src_q;
	logic [CNT_W-1:0]     head_q, tail_q;
	logic [MAX_NODES-1:0] reached_q;
	logic [NODE_W-1:0]    cur_node_q;
	logic [DIST_W-1:0]    cur_dist_q;
	logic [SLOT_W:0]      slot_q;
	logic                 rd_s1;
	logic [SUM_W-1:0]     sum_q;
	logic                 done_q;

	logic                 adj_we;
	logic [ADJ_AW-1:0]    adj_waddr, adj_raddr;
	logic [ADJ_W-1:0]     adj_wdata, adj_rdata;
	logic                 que_we;
	logic [NODE_W-1:0]    que_waddr;
	logic [QUE_W-1:0]     que_wdata, que_rdata;

	logic                 accept;
	logic                 cfg_wr;
	logic                 nb_take;
	logic [DIST_W-1:0]    nb_dist;
	logic [SUM_W:0]       sum_add;
	logic                 last_src;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_NODE_COUNT);
	assign prdata = (paddr == REG_NODE_COUNT) ? {{(32-CNT_W){1'b0}}, node_count_q} : 32'd0;

	assign n_eff = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign distance_sum = sum_q;
	assign last_src = ({1'b0, src_q} == n_eff - CNT_W'(1));

	// neighbor returned from the adjacency ram in the cycle after its slot read
	assign nb_dist = cur_dist_q + DIST_W'(1);
	assign nb_take = rd_s1 && adj_rdata[ADJ_W-1] && ({1'b0, adj_rdata[NODE_W-1:0]} < n_eff)
		&& !reached_q[adj_rdata[NODE_W-1:0]];
	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(nb_dist);

	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = {node_index, slot_index};
		adj_wdata = {slot_present, neighbor_node};
		if (state_q == ST_CLEAR) begin
			adj_we    = 1'b1;
			adj_waddr = clr_q[ADJ_AW-1:0];
			adj_wdata = '0;
		end else if (accept && !mode) begin
			adj_we = 1'b1;
		end
	end
	assign adj_raddr = {cur_node_q, slot_q[SLOT_W-1:0]};

	always_comb begin
		que_we    = 1'b0;
		que_waddr = tail_q[NODE_W-1:0];
		que_wdata = {adj_rdata[NODE_W-1:0], nb_dist};
		if (state_q == ST_SRC_INIT) begin
			que_we    = 1'b1;
			que_waddr = '0;
			que_wdata = {src_q, DIST_W'(0)};
		end else if (state_q == ST_NBR && nb_take) begin
			que_we = 1'b1;
		end
	end

	gds_ram #(.WIDTH(ADJ_W), .DEPTH(ADJ_DEPTH)) u_adj (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	gds_ram #(.WIDTH(QUE_W), .DEPTH(MAX_NODES)) u_que (
		.clk   (clk),
		.we    (que_we),
		.waddr (que_waddr),
		.wdata (que_wdata),
		.raddr (head_q[NODE_W-1:0]),
		.rdata (que_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == (ADJ_AW+1)'(ADJ_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && mode && (n_eff != '0)) state_d = ST_SRC_INIT;
			end
			ST_SRC_INIT: state_d = ST_POP;
			ST_POP: begin
				if (head_q == tail_q) begin
					state_d = last_src ? ST_IDLE : ST_SRC_INIT;
				end else begin
					state_d = ST_POP_WAIT;
				end
			end
			ST_POP_WAIT: state_d = ST_NBR;
			ST_NBR: begin
				if (slot_q == (SLOT_W+1)'(MAX_DEGREE)) state_d = ST_POP;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			node_count_q <= CNT_W'(MAX_NODES);
			clr_q        <= '0;
			src_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			reached_q    <= '0;
			cur_node_q   <= '0;
			cur_dist_q   <= '0;
			slot_q       <= '0;
			rd_s1        <= 1'b0;
			sum_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			// zero-node compute ends at once, otherwise after the last source drains
			done_q  <= ((state_q == ST_IDLE) && accept && mode && (n_eff == '0))
				|| ((state_q == ST_POP) && (head_q == tail_q) && last_src);
			rd_s1   <= (state_q == ST_NBR) && (slot_q != (SLOT_W+1)'(MAX_DEGREE));
			if (cfg_wr) node_count_q <= pwdata[CNT_W-1:0];
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + (ADJ_AW+1)'(1);
				ST_IDLE: begin
					if (accept && mode) begin
						sum_q <= '0;
						src_q <= '0;
					end
				end
				ST_SRC_INIT: begin
					reached_q <= MAX_NODES'(1) << src_q;
					head_q    <= '0;
					tail_q    <= CNT_W'(1);
				end
				ST_POP: begin
					if (head_q == tail_q) begin
						if (!last_src) src_q <= src_q + NODE_W'(1);
					end else begin
						head_q <= head_q + CNT_W'(1);
					end
				end
				ST_POP_WAIT: begin
					cur_node_q <= que_rdata[QUE_W-1:DIST_W];
					cur_dist_q <= que_rdata[DIST_W-1:0];
					slot_q     <= '0;
				end
				ST_NBR: begin
					if (slot_q != (SLOT_W+1)'(MAX_DEGREE)) begin
						slot_q <= slot_q + (SLOT_W+1)'(1);
					end
					if (nb_take) begin
						reached_q[adj_rdata[NODE_W-1:0]] <= 1'b1;
						tail_q <= tail_q + CNT_W'(1);
						sum_q  <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/gds_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`default_nettype none
module gds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### design/gds_checker.sv
// port-level checker for graph_distance_sum, bound to the top level
// depends on the top level port list only
`default_nettype none
module gds_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic mode,
	input wire logic done
);
	// a result word only ends a compute run
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && mode)))
		else $error("done without a compute run");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while still busy");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !mode) |=> !done)
		else $error("load word produced a result");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode) |=> (busy || done))
		else $error("compute word dropped");
endmodule

bind graph_distance_sum gds_checker u_gds_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.mode   (mode),
	.done   (done)
);
`default_nettype wire
